// ===== rtl/dq_pkg.sv =====
`default_nettype none

package dq_pkg;

  // request codes
  typedef enum logic [2:0] {
    KIND_PUSH_BACK  = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_CLEAR      = 3'd4,
    KIND_QUERY      = 3'd5
  } kind_e;

  // error codes
  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic look;
  } dq_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/dq_ctrl.sv =====
`default_nettype none

module dq_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output dq_pkg::dq_cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOOK,
    ST_RESP
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q, in_ready_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    in_ready_d  = in_ready_q;
    out_valid_d = out_valid_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d    = ST_EXEC;
          in_ready_d = 1'b0;
        end
      end
      ST_EXEC: begin
        state_d = ST_LOOK;
      end
      ST_LOOK: begin
        state_d     = ST_RESP;
        out_valid_d = 1'b1;
      end
      ST_RESP: begin
        if (out_ready_i) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b0;
          in_ready_d  = 1'b1;
        end
      end
      default: begin
        state_d     = ST_IDLE;
        in_ready_d  = 1'b1;
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_ready_q  <= in_ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o      = '0;
    cmd_o.load = in_valid_i & in_ready_q;
    cmd_o.exec = (state_q == ST_EXEC);
    cmd_o.look = (state_q == ST_LOOK);
  end

endmodule

`default_nettype wire

// ===== rtl/dq_datapath.sv =====
`default_nettype none

module dq_datapath #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned WORD_WIDTH  = 32,
  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dq_pkg::dq_cmd_t       cmd_i,
  input  wire logic [2:0]            kind_i,
  input  wire logic [WORD_WIDTH-1:0] data_in_i,
  output logic [WORD_WIDTH-1:0]      popped_value_o,
  output logic [1:0]                 error_code_o,
  output logic [WORD_WIDTH-1:0]      front_value_o,
  output logic [WORD_WIDTH-1:0]      back_value_o,
  output logic [CntW-1:0]            element_count_o,
  output logic                       is_empty_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  function automatic logic [IdxW-1:0] idx_next(input logic [IdxW-1:0] i);
    return (i == LastIdx) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] idx_prev(input logic [IdxW-1:0] i);
    return (i == '0) ? LastIdx : i - 1'b1;
  endfunction

  logic [WORD_WIDTH-1:0] mem [QUEUE_DEPTH];

  logic [2:0]            kind_q;
  logic [WORD_WIDTH-1:0] data_q;
  logic [IdxW-1:0]       front_q, front_d;
  logic [IdxW-1:0]       back_q, back_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [1:0]            err_q, err_d;
  logic                  pop_ok_q, pop_ok_d;
  logic [WORD_WIDTH-1:0] popped_q;

  logic                  we;
  logic [IdxW-1:0]       waddr;
  logic                  re_a, re_b;
  logic [IdxW-1:0]       raddr_a, raddr_b;
  logic [WORD_WIDTH-1:0] rd_a_q, rd_b_q;

  logic full, empty;

  assign full  = (count_q == FullCnt);
  assign empty = (count_q == '0);

  // request execution and end word fetch
  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    count_d  = count_q;
    err_d    = err_q;
    pop_ok_d = pop_ok_q;
    we       = 1'b0;
    waddr    = back_q;
    re_a     = 1'b0;
    raddr_a  = front_q;
    re_b     = 1'b0;
    raddr_b  = idx_prev(back_q);
    if (cmd_i.exec) begin
      err_d    = dq_pkg::ERR_OK;
      pop_ok_d = 1'b0;
      case (kind_q)
        dq_pkg::KIND_PUSH_BACK: begin
          if (full) begin
            err_d = dq_pkg::ERR_FULL;
          end else begin
            we      = 1'b1;
            waddr   = back_q;
            back_d  = idx_next(back_q);
            count_d = count_q + 1'b1;
          end
        end
        dq_pkg::KIND_PUSH_FRONT: begin
          if (full) begin
            err_d = dq_pkg::ERR_FULL;
          end else begin
            we      = 1'b1;
            waddr   = idx_prev(front_q);
            front_d = idx_prev(front_q);
            count_d = count_q + 1'b1;
          end
        end
        dq_pkg::KIND_POP_FRONT: begin
          if (empty) begin
            err_d = dq_pkg::ERR_EMPTY;
          end else begin
            re_a     = 1'b1;
            raddr_a  = front_q;
            pop_ok_d = 1'b1;
            front_d  = idx_next(front_q);
            count_d  = count_q - 1'b1;
          end
        end
        dq_pkg::KIND_POP_BACK: begin
          if (empty) begin
            err_d = dq_pkg::ERR_EMPTY;
          end else begin
            re_a     = 1'b1;
            raddr_a  = idx_prev(back_q);
            pop_ok_d = 1'b1;
            back_d   = idx_prev(back_q);
            count_d  = count_q - 1'b1;
          end
        end
        dq_pkg::KIND_CLEAR: begin
          front_d = '0;
          back_d  = '0;
          count_d = '0;
        end
        default: begin
        end
      endcase
    end else if (cmd_i.look) begin
      // fetch both end words at the updated pointers
      re_a    = 1'b1;
      raddr_a = front_q;
      re_b    = 1'b1;
      raddr_b = idx_prev(back_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      back_q   <= '0;
      count_q  <= '0;
      err_q    <= dq_pkg::ERR_OK;
      pop_ok_q <= 1'b0;
    end else begin
      front_q  <= front_d;
      back_q   <= back_d;
      count_q  <= count_d;
      err_q    <= err_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      data_q <= data_in_i;
    end
    if (cmd_i.look) begin
      popped_q <= pop_ok_q ? rd_a_q : '0;
    end
  end

  // ring store
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= data_q;
    end
    if (re_a) begin
      rd_a_q <= mem[raddr_a];
    end
    if (re_b) begin
      rd_b_q <= mem[raddr_b];
    end
  end

  assign popped_value_o  = popped_q;
  assign error_code_o    = err_q;
  assign front_value_o   = empty ? '0 : rd_a_q;
  assign back_value_o    = empty ? '0 : rd_b_q;
  assign element_count_o = count_q;
  assign is_empty_o      = empty;

endmodule

`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
// channel   direction  handshake              payload
// request   in         in_valid_i/in_ready_o   kind_i, data_in_i
// result    out        out_valid_o/out_ready_i popped_value_o, error_code_o, front_value_o,
//                                              back_value_o, element_count_o, is_empty_o
//
// one word at a time; each word passes through accept, execute with store
// write or pop read, end word fetch and result
// both end words are read through the single two-read-port ring store
// reset clears pointers and count; store contents are left as they are
// a stalled result holds the request side off until it is taken
`default_nettype none

module double_ended_queue #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned WORD_WIDTH  = 32,
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [2:0]            kind_i,
  input  wire logic [WORD_WIDTH-1:0] data_in_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [WORD_WIDTH-1:0]      popped_value_o,
  output logic [1:0]                 error_code_o,
  output logic [WORD_WIDTH-1:0]      front_value_o,
  output logic [WORD_WIDTH-1:0]      back_value_o,
  output logic [CntW-1:0]            element_count_o,
  output logic                       is_empty_o
);

  dq_pkg::dq_cmd_t cmd;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  dq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .WORD_WIDTH  (WORD_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .kind_i          (kind_i),
    .data_in_i       (data_in_i),
    .popped_value_o  (popped_value_o),
    .error_code_o    (error_code_o),
    .front_value_o   (front_value_o),
    .back_value_o    (back_value_o),
    .element_count_o (element_count_o),
    .is_empty_o      (is_empty_o)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    element_count_o <= CntW'(QUEUE_DEPTH))
    else $error("count above depth");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("request taken while result pending");

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> ##3 out_valid_o)
    else $error("result not shown three cycles after word");

  a_error_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_o) && error_code_o != dq_pkg::ERR_OK) |-> $stable(element_count_o))
    else $error("rejected word changed count");

endmodule

`default_nettype wire
